// ===== rtl/core/rc4_pkg.sv =====
// rc4 cipher package: word types, controller commands and status, constants
`default_nettype none

package rc4_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int KEY_BYTES     = 16;
    localparam int KEY_SEL_W     = $clog2(KEY_BYTES);
    localparam int BYTE_W        = 8;

    localparam logic MODE_REKEY = 1'b0;
    localparam logic MODE_CRYPT = 1'b1;

    localparam logic [IDX_W-1:0] I_START = IDX_W'(1);
    localparam logic [IDX_W-1:0] J_START = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

    typedef struct packed {
        logic              mode;
        logic [63:0]       key_high;
        logic [63:0]       key_low;
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } rc4_in_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_last;
    } rc4_out_word_t;

    typedef struct packed {
        logic load;
        logic fill;
        logic s_rdn;
        logic s_rda;
        logic s_wrn;
        logic s_wra;
        logic k_rdi;
        logic k_rdj;
        logic k_wra;
        logic k_wrb;
        logic out_load;
    } rc4_cmd_t;

    typedef struct packed {
        logic cnt_last;
    } rc4_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/rc4_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rc4_ctrl.sv =====
// rc4 controller: sequences key fill, key schedule and keystream steps
`default_nettype none

module rc4_ctrl import rc4_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    input  wire logic      req_mode,
    input  wire logic      rsp_stall,
    input  wire rc4_stat_t stat,
    output      rc4_cmd_t  cmd,
    output      logic      req_stall,
    output      logic      rsp_valid
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FILL  = 4'd1;
    localparam logic [3:0] ST_S_RDN = 4'd2;
    localparam logic [3:0] ST_S_RDA = 4'd3;
    localparam logic [3:0] ST_S_WRN = 4'd4;
    localparam logic [3:0] ST_S_WRA = 4'd5;
    localparam logic [3:0] ST_K_RDI = 4'd6;
    localparam logic [3:0] ST_K_RDJ = 4'd7;
    localparam logic [3:0] ST_K_WRA = 4'd8;
    localparam logic [3:0] ST_K_WRB = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       accept;
    logic       out_free;

    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = (req_mode == MODE_REKEY) ? ST_FILL : ST_K_RDI;
                end
            end
            ST_FILL:
            begin
                cmd.fill = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = ST_S_RDN;
                end
            end
            ST_S_RDN:
            begin
                cmd.s_rdn  = 1'b1;
                state_next = ST_S_RDA;
            end
            ST_S_RDA:
            begin
                cmd.s_rda  = 1'b1;
                state_next = ST_S_WRN;
            end
            ST_S_WRN:
            begin
                cmd.s_wrn  = 1'b1;
                state_next = ST_S_WRA;
            end
            ST_S_WRA:
            begin
                cmd.s_wra  = 1'b1;
                state_next = stat.cnt_last ? ST_IDLE : ST_S_RDN;
            end
            ST_K_RDI:
            begin
                cmd.k_rdi  = 1'b1;
                state_next = ST_K_RDJ;
            end
            ST_K_RDJ:
            begin
                cmd.k_rdj  = 1'b1;
                state_next = ST_K_WRA;
            end
            ST_K_WRA:
            begin
                cmd.k_wra  = 1'b1;
                state_next = ST_K_WRB;
            end
            ST_K_WRB:
            begin
                cmd.k_wrb = 1'b1;
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        priority if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rsp_valid_reg || !rsp_stall))
        else $error("result loaded over a pending word");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted word did not start work");

    a_sched_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_S_WRA) && stat.cnt_last |=> (state_reg == ST_IDLE))
        else $error("key schedule did not end after last entry");

    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.fill, cmd.s_rdn, cmd.s_rda, cmd.s_wrn, cmd.s_wra,
                  cmd.k_rdi, cmd.k_rdj, cmd.k_wra, cmd.k_wrb}))
        else $error("more than one datapath step at once");

    a_rsp_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> rsp_valid)
        else $error("result word not shown after load");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/rc4_dp.sv =====
// rc4 datapath: permutation ram, indexes, key register and result register
`default_nettype none

module rc4_dp import rc4_pkg::*; (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire rc4_cmd_t      cmd,
    input  wire rc4_in_word_t  req_word,
    output      rc4_stat_t     stat,
    output      rc4_out_word_t rsp_word
);

    logic [2*64-1:0]     key_reg;
    logic [BYTE_W-1:0]   data_reg;
    logic                last_reg;
    logic [IDX_W-1:0]    cnt_reg;
    logic [IDX_W-1:0]    acc_reg;
    logic [IDX_W-1:0]    i_reg;
    logic [IDX_W-1:0]    j_reg;
    logic [BYTE_W-1:0]   va_reg;
    logic [BYTE_W-1:0]   vb_reg;
    logic [IDX_W-1:0]    t_reg;
    rc4_out_word_t       out_reg;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [BYTE_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [BYTE_W-1:0]   ram_rdata;

    logic [KEY_SEL_W-1:0] key_sel;
    logic [BYTE_W-1:0]    key_byte;
    logic [IDX_W-1:0]     acc_next;
    logic [IDX_W-1:0]     j_next;
    logic [IDX_W-1:0]     t_next;
    logic [BYTE_W-1:0]    ks_byte;

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_perm (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // key byte n mod 16, first byte in the top bits
    assign key_sel  = KEY_SEL_W'(KEY_BYTES - 1) - cnt_reg[KEY_SEL_W-1:0];
    assign key_byte = key_reg[{key_sel, 3'b000} +: BYTE_W];
    assign acc_next = acc_reg + key_byte + ram_rdata;
    assign j_next   = j_reg + ram_rdata;
    assign t_next   = va_reg + ram_rdata;

    // read of s[t] returned pre-swap data
    always_comb
    begin
        priority if (t_reg == j_reg)
        begin
            ks_byte = va_reg;
        end
        else if (t_reg == i_reg)
        begin
            ks_byte = vb_reg;
        end
        else
        begin
            ks_byte = ram_rdata;
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = cnt_reg;
        priority if (cmd.fill)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.s_wrn)
        begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
        end
        else if (cmd.s_wra)
        begin
            ram_we    = 1'b1;
            ram_waddr = acc_reg;
            ram_wdata = va_reg;
        end
        else if (cmd.k_wra)
        begin
            ram_we    = 1'b1;
            ram_waddr = i_reg;
            ram_wdata = ram_rdata;
        end
        else if (cmd.k_wrb)
        begin
            ram_we    = 1'b1;
            ram_waddr = j_reg;
            ram_wdata = va_reg;
        end
    end

    always_comb
    begin
        ram_re    = 1'b1;
        ram_raddr = cnt_reg;
        priority if (cmd.s_rdn)
        begin
            ram_raddr = cnt_reg;
        end
        else if (cmd.s_rda)
        begin
            ram_raddr = acc_next;
        end
        else if (cmd.k_rdi)
        begin
            ram_raddr = i_reg;
        end
        else if (cmd.k_rdj)
        begin
            ram_raddr = j_next;
        end
        else if (cmd.k_wra)
        begin
            ram_raddr = t_next;
        end
        else
        begin
            ram_re = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            i_reg   <= I_START;
            j_reg   <= J_START;
        end
        else
        begin
            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.fill || cmd.s_wra)
            begin
                cnt_reg <= cnt_reg + IDX_W'(1);
            end

            if (cmd.load && (req_word.mode == MODE_REKEY))
            begin
                i_reg <= I_START;
                j_reg <= J_START;
            end
            else
            begin
                if (cmd.k_rdj)
                begin
                    j_reg <= j_next;
                end
                if (cmd.out_load)
                begin
                    i_reg <= i_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= {req_word.key_high, req_word.key_low};
            data_reg <= req_word.data_byte;
            last_reg <= req_word.last_byte;
            acc_reg  <= '0;
        end
        if (cmd.s_rda)
        begin
            acc_reg <= acc_next;
            va_reg  <= ram_rdata;
        end
        if (cmd.k_rdj)
        begin
            va_reg <= ram_rdata;
        end
        if (cmd.k_wra)
        begin
            vb_reg <= ram_rdata;
            t_reg  <= t_next;
        end
        if (cmd.out_load)
        begin
            out_reg.out_byte <= data_reg ^ ks_byte;
            out_reg.out_last <= last_reg;
        end
    end

    assign stat.cnt_last = (cnt_reg == IDX_LAST);
    assign rsp_word      = out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rc4_stream_cipher_top.sv =====
// rc4 stream cipher top level: controller plus datapath
//
//  channel | valid     | stall     | word     | moves
//  req     | req_valid | req_stall | req_word | rekey or one data byte in
//  rsp     | rsp_valid | rsp_stall | rsp_word | one crypted byte out
//
// a rekey word runs an identity fill of the permutation table, then four permutation
// ram accesses per schedule step on its single read and write port
// a data word runs four ram steps after accept and loads its result into the output
// register in the last of them
// reset sets i to 1 and j to 0; the permutation table holds nothing until a rekey
// a pending result does not block the next accept; a data word whose result finds
// the output register still stalled waits in its last step until it frees
`default_nettype none

module rc4_stream_cipher_top import rc4_pkg::*; (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output      logic          req_stall,
    input  wire rc4_in_word_t  req_word,
    output      logic          rsp_valid,
    input  wire logic          rsp_stall,
    output      rc4_out_word_t rsp_word
);

    rc4_cmd_t  cmd;
    rc4_stat_t stat;

    rc4_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_mode  (req_word.mode),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid)
    );

    rc4_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_word (req_word),
        .stat     (stat),
        .rsp_word (rsp_word)
    );

endmodule

`default_nettype wire

// ===== bench/rc4_checker.sv =====
// rc4 checker: watches both channels, predicts each crypted word and compares it
module rc4_checker import rc4_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_stall,
    input  rc4_in_word_t  req_word,
    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  rc4_out_word_t rsp_word,
    output int            errors,
    output int            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [BYTE_W-1:0] perm [TABLE_ENTRIES];
    logic [IDX_W-1:0]  ptr_i;
    logic [IDX_W-1:0]  ptr_j;
    rc4_out_word_t     expected_bytes [$];
    rc4_out_word_t     want;
    rc4_out_word_t     made;
    int                fail_count;

    function automatic void schedule_key(input logic [63:0] hi, input logic [63:0] lo);
        logic [127:0]      key;
        logic [IDX_W-1:0]  acc;
        logic [BYTE_W-1:0] kb;
        logic [BYTE_W-1:0] t;
        int                k;
        key = {hi, lo};
        for (int n = 0; n < TABLE_ENTRIES; n++)
            perm[n] = n[BYTE_W-1:0];
        acc = '0;
        for (int n = 0; n < TABLE_ENTRIES; n++)
        begin
            k = n % KEY_BYTES;
            kb = key[127 - 8*k -: 8];
            acc = acc + kb + perm[n];
            t = perm[n];
            perm[n] = perm[acc];
            perm[acc] = t;
        end
        ptr_i = I_START;
        ptr_j = J_START;
    endfunction

    function automatic logic [BYTE_W-1:0] keystream_byte();
        logic [IDX_W-1:0]  a;
        logic [IDX_W-1:0]  b;
        logic [BYTE_W-1:0] va;
        logic [BYTE_W-1:0] vb;
        logic [IDX_W-1:0]  s;
        a = ptr_i;
        va = perm[a];
        b = ptr_j + va;
        vb = perm[b];
        perm[a] = vb;
        perm[b] = va;
        ptr_i = a + 1'b1;
        ptr_j = b;
        s = va + vb;
        return perm[s];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < TABLE_ENTRIES; n++)
                perm[n] = '0;
            ptr_i = I_START;
            ptr_j = J_START;
            expected_bytes.delete();
            fail_count = 0;
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual byte %02h last %0b",
                             $time, rsp_word.out_byte, rsp_word.out_last);
                    fail_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (rsp_word.out_byte !== want.out_byte)
                    begin
                        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                                 $time, want.out_byte, rsp_word.out_byte);
                        fail_count++;
                    end
                    if (rsp_word.out_last !== want.out_last)
                    begin
                        $display("%0t: out_last mismatch: expected %0b, actual %0b",
                                 $time, want.out_last, rsp_word.out_last);
                        fail_count++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                if (req_word.mode == MODE_REKEY)
                    schedule_key(req_word.key_high, req_word.key_low);
                else
                begin
                    made.out_byte = req_word.data_byte ^ keystream_byte();
                    made.out_last = req_word.last_byte;
                    expected_bytes.push_back(made);
                end
            end
            errors <= fail_count;
            pending <= expected_bytes.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
// rc4 testbench top: clock, reset, word stimulus, receiver stalls, watchdog and verdict
module tb import rc4_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS       = 400;
    localparam int CALM_AFTER  = 360;
    localparam int WRAP_RUN    = 280;
    localparam int HOLD_CYCLES = 200;
    localparam int IDLE_LIMIT  = 10000;
    localparam int DRAIN       = 20;

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    rc4_in_word_t  req_word;
    logic          rsp_valid;
    logic          rsp_stall;
    rc4_out_word_t rsp_word;
    int            fail_total;
    int            open_count;
    int            items_sent;
    int            idle_cycles;
    bit            calm;
    bit            hold_go;
    bit            hold_done;

    rc4_stream_cipher_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    rc4_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .errors    (fail_total),
        .pending   (open_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [63:0] pick_key();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic put_word(input rc4_in_word_t w);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_word <= w;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_rekey(input logic [63:0] hi, input logic [63:0] lo);
        rc4_in_word_t w;
        w.mode = MODE_REKEY;
        w.key_high = hi;
        w.key_low = lo;
        w.data_byte = BYTE_W'($urandom_range(0, 255));
        w.last_byte = 1'($urandom_range(0, 1));
        put_word(w);
    endtask

    task automatic send_data(input logic [BYTE_W-1:0] b, input logic last);
        rc4_in_word_t w;
        w.mode = MODE_CRYPT;
        w.key_high = {$urandom(), $urandom()};
        w.key_low = {$urandom(), $urandom()};
        w.data_byte = b;
        w.last_byte = last;
        put_word(w);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_word = '0;
        items_sent = 0;
        calm = 1'b0;
        hold_go = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_rekey('0, '0);
        send_data(8'h00, 1'b0);
        send_data(8'hFF, 1'b1);
        send_data(8'hA5, 1'b0);
        send_rekey('1, '1);
        send_data(8'h5A, 1'b1);
        send_data(8'hFF, 1'b0);
        send_data(8'h00, 1'b1);
        send_rekey(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
        send_data(8'h3C, 1'b0);
        send_data(8'hC3, 1'b0);
        send_data(8'h81, 1'b1);
        send_rekey({16{4'hA}}, {16{4'h5}});
        send_data(8'h01, 1'b0);
        send_data(8'h80, 1'b1);
        send_rekey({16{4'h5}}, {16{4'hA}});
        send_data(8'h7F, 1'b0);
        send_data(8'hFE, 1'b1);
        send_rekey('0, '1);
        send_data(8'h55, 1'b1);

        // long run past the index wrap, with the receiver held off at its start
        send_rekey(pick_key(), pick_key());
        hold_go = 1'b1;
        for (int n = 0; n < WRAP_RUN; n++)
            send_data(BYTE_W'($urandom_range(0, 255)), (n % 16) == 15);

        while (items_sent < ITEMS)
        begin
            if (items_sent >= CALM_AFTER)
                calm = 1'b1;
            send_rekey(pick_key(), pick_key());
            if ($urandom_range(0, 7) != 0)
            begin
                automatic int burst = $urandom_range(1, 16);
                for (int n = 0; n < burst; n++)
                    send_data(BYTE_W'($urandom_range(0, 255)), n == burst - 1);
            end
        end
        calm = 1'b1;
        req_valid <= 1'b0;

        while (open_count != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
        if (fail_total == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rsp_stall = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_done)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                rsp_stall <= 1'b0;
                hold_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                rsp_stall <= 1'b0;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    initial
        idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule

// ===== rc4_stream_cipher_top.f =====
rtl/core/rc4_pkg.sv
rtl/core/rc4_ram.sv
rtl/core/rc4_ctrl.sv
rtl/core/rc4_dp.sv
rtl/core/rc4_stream_cipher_top.sv
bench/rc4_checker.sv
bench/tb.sv
